>>> design/least_slack_task_scheduler_assert.svh
// Assertion macros shared by the scheduler RTL.
`ifndef LEAST_SLACK_TASK_SCHEDULER_ASSERT_SVH
`define LEAST_SLACK_TASK_SCHEDULER_ASSERT_SVH

// Same-cycle implication, sampled on clock and disabled while reset is high.
`define LSTS_ASSERT_IMPLY(label, cond, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error("scheduler: same-cycle check failed");

// Next-cycle implication, sampled on clock and disabled while reset is high.
`define LSTS_ASSERT_NEXT(label, cond, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error("scheduler: next-cycle check failed");

`endif

>>> design/lsts_pkg.sv
// Shared constants and types of the least-slack task scheduler.
package lsts_pkg;

   localparam int MAX_TASK_SLOTS  = 32;
   localparam int SLOT_BITS       = $clog2(MAX_TASK_SLOTS);
   localparam int SCAN_BITS       = SLOT_BITS + 1;
   localparam int TIME_BITS       = 16;
   localparam int COUNT_BITS      = 16;
   localparam int SLACK_BITS      = TIME_BITS + 2;
   localparam int SLACK_CEILING   = 1024;
   localparam int TASK_COUNT_BITS = 6;
   localparam int FUNC_BITS       = 2;
   localparam int CSR_ADDR_BITS   = 3;
   localparam int CSR_DATA_BITS   = 32;

   // Register word index within the configuration space.
   localparam logic REG_TASK_COUNT = 1'b0;

   typedef enum logic [FUNC_BITS-1:0] {
      FUNC_LOAD  = 2'd0,
      FUNC_TICK  = 2'd1,
      FUNC_CLOSE = 2'd2,
      FUNC_NONE  = 2'd3
   } func_type;

   // One task slot as held in the task table; period is stored already clamped to one.
   typedef struct packed {
      logic [TIME_BITS-1:0] cost;
      logic [TIME_BITS-1:0] period;
      logic [TIME_BITS-1:0] deadline;
      logic [TIME_BITS-1:0] remaining;
      logic [TIME_BITS-1:0] next_release;
      logic [TIME_BITS-1:0] phase;
   } task_entry_type;

   typedef struct packed {
      logic                 wr_en;
      logic [SLOT_BITS-1:0] wr_addr;
      task_entry_type       wr_data;
      logic                 rd_en;
      logic [SLOT_BITS-1:0] rd_addr;
   } mem_req_type;

endpackage

>>> design/least_slack_task_scheduler.sv
// Least-slack-time scheduler for periodic tasks: top level and tick sequencer.
//
// Input beats arrive on req_: tuser carries the function (load, tick, closing
// tick), tdata the slot, cost, period and relative deadline of a load. Every
// input beat yields exactly one result beat on rsp_ with the chosen task, the
// idle, late and executed flags and the two saturating event counters.
// The task_count register sits at byte address 0 of the csr_ APB port.
//
// A load or an unrecognised function goes from the taken beat straight to the
// completion state. A tick or closing tick walks all 32 task slots through one
// shared slot evaluator, one slot per cycle through a two-stage pipeline
// behind the registered table read, and then completes. req_tready is high
// only between items, so the block takes no new item before the last one
// has completed.
//
// The result is held in an output register; the next item is accepted while
// it waits, but that item only completes once the receiver has taken it.
// After reset task_count is 1, time and counters are zero and the task table
// holds no meaningful contents until each slot is loaded.
module least_slack_task_scheduler
   import lsts_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   // Input beat.
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // tdata from bit 0: task_slot[4:0], compute_time[20:5], period_len[36:21],
   // rel_deadline[52:37], zero fill[55:53].
   input  logic [55:0]              req_tdata,
   // tuser from bit 0: func[1:0].
   input  logic [FUNC_BITS-1:0]     req_tuser,
   // Result beat.
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // tdata from bit 0: running_task[4:0], idle[5], late[6], executed[7],
   // switch_count[23:8], preempt_count[39:24].
   output logic [39:0]              rsp_tdata,
   // Configuration port.
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
      return (&v) ? v : v + 1'b1;
   endfunction

   // Configuration register.
   logic [TASK_COUNT_BITS-1:0] task_count_ff;
   logic [TASK_COUNT_BITS-1:0] task_count_in;
   logic [TASK_COUNT_BITS-1:0] n_eff;
   logic                       csr_write;

   // Sequencer and item latch.
   state_type              state_ff, state_in;
   func_type               func_ff, func_in;
   logic [SLOT_BITS-1:0]   item_slot_ff, item_slot_in;
   logic [TIME_BITS-1:0]   item_cost_ff, item_cost_in;
   logic [TIME_BITS-1:0]   item_period_ff, item_period_in;
   logic [TIME_BITS-1:0]   item_deadline_ff, item_deadline_in;

   // Scheduler state.
   logic [TIME_BITS-1:0]   now_ff, now_in;
   logic [SLOT_BITS-1:0]   prev_task_ff, prev_task_in;
   logic                   prev_idle_ff, prev_idle_in;
   logic                   first_tick_ff, first_tick_in;
   logic [COUNT_BITS-1:0]  switches_ff, switches_in;
   logic [COUNT_BITS-1:0]  preempts_ff, preempts_in;

   // Scan pipeline.
   logic [SCAN_BITS-1:0]   scan_idx_ff, scan_idx_in;
   logic                   rd_valid_ff, rd_valid_in;
   logic [SLOT_BITS-1:0]   rd_idx_ff;
   logic                   s2_valid_ff, s2_valid_in;
   logic [SLOT_BITS-1:0]   s2_idx_ff;
   logic                   s2_active_ff, s2_active_in;
   task_entry_type         s2_entry_ff, s2_entry_in;

   // Best candidate and previous-task capture.
   logic                   found_ff, found_in;
   logic signed [SLACK_BITS-1:0] best_slack_ff, best_slack_in;
   logic [SLOT_BITS-1:0]   best_idx_ff, best_idx_in;
   task_entry_type         best_entry_ff, best_entry_in;
   logic [TIME_BITS-1:0]   pv_rem_ff, pv_rem_in;
   logic [TIME_BITS-1:0]   pv_cost_ff, pv_cost_in;

   // Result register.
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [39:0]            rsp_data_ff, rsp_data_in;

   // Table access.
   mem_req_type            mem_req;
   task_entry_type         rd_data;

   logic                   req_beat;
   logic                   out_free;
   logic                   scan_issue;
   logic                   scan_drained;

   // First evaluator stage.
   logic                   s1_active;
   logic [TIME_BITS:0]     s1_ph_inc;
   logic [TIME_BITS-1:0]   s1_phase;
   logic                   s1_release;
   task_entry_type         s1_entry;

   // Second evaluator stage.
   logic signed [SLACK_BITS-1:0] s2_slack;
   logic [TIME_BITS-1:0]   s2_next_release;
   task_entry_type         s2_wr_entry;
   logic                   s2_take;

   // Tick completion.
   logic                   cur_idle;
   logic [SLOT_BITS-1:0]   chosen;
   logic                   executed;
   logic                   late;
   logic                   differs;
   logic                   sw_bump;
   logic                   pre_bump;
   logic [TIME_BITS-1:0]   load_period;
   task_entry_type         load_entry;
   task_entry_type         run_entry;

   lsts_task_mem u_task_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == REG_TASK_COUNT)
                       ? {{(CSR_DATA_BITS-TASK_COUNT_BITS){1'b0}}, task_count_ff}
                       : '0;

   assign n_eff = (task_count_ff > TASK_COUNT_BITS'(MAX_TASK_SLOTS))
                  ? TASK_COUNT_BITS'(MAX_TASK_SLOTS) : task_count_ff;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_beat   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign scan_issue   = (state_ff == ST_SCAN) && (scan_idx_ff < SCAN_BITS'(MAX_TASK_SLOTS));
   assign scan_drained = !scan_issue && !rd_valid_ff && !s2_valid_ff;

   // Stage one: advance the phase of now within the period and apply a release.
   always_comb begin
      s1_active  = {1'b0, rd_idx_ff} < n_eff;
      s1_ph_inc  = {1'b0, rd_data.phase} + 1'b1;
      if (now_ff == '0) begin
         s1_phase = '0;
      end else if (s1_ph_inc == {1'b0, rd_data.period}) begin
         s1_phase = '0;
      end else begin
         s1_phase = s1_ph_inc[TIME_BITS-1:0];
      end
      s1_release = s1_active && (now_ff == rd_data.next_release);
      s1_entry       = rd_data;
      s1_entry.phase = s1_phase;
      if (s1_release) begin
         s1_entry.remaining = rd_data.cost;
      end
   end

   // Stage two: slack, candidate compare and write-back of the refreshed slot.
   always_comb begin
      s2_slack = $signed({2'b00, s2_entry_ff.deadline})
               - $signed({2'b00, s2_entry_ff.phase})
               - $signed({2'b00, s2_entry_ff.remaining});
      s2_next_release = now_ff - s2_entry_ff.phase + s2_entry_ff.period;
      s2_wr_entry = s2_entry_ff;
      if (s2_active_ff) begin
         s2_wr_entry.next_release = s2_next_release;
      end
      s2_take = s2_valid_ff && s2_active_ff && (s2_entry_ff.remaining != '0)
                && (s2_slack < best_slack_ff);
   end

   // Outcome of a tick once the scan is complete.
   always_comb begin
      cur_idle = !found_ff;
      chosen   = found_ff ? best_idx_ff : '0;
      executed = found_ff && (func_ff == FUNC_TICK);
      late     = executed && (({1'b0, best_entry_ff.phase} + 1'b1)
                              > {1'b0, best_entry_ff.deadline});
      differs  = (cur_idle != prev_idle_ff) || (!cur_idle && (chosen != prev_task_ff));
      sw_bump  = 1'b0;
      pre_bump = 1'b0;
      if (!first_tick_ff) begin
         if (differs) begin
            sw_bump = 1'b1;
            // A task left part-way through its job counts as preempted.
            if (!prev_idle_ff && (pv_rem_ff != '0) && (pv_rem_ff != pv_cost_ff)) begin
               pre_bump = 1'b1;
            end else if (cur_idle && (func_ff == FUNC_TICK)) begin
               pre_bump = 1'b1;
            end
         end else if (!cur_idle && (best_entry_ff.phase == '0)) begin
            // The same task running across its own release boundary.
            sw_bump = 1'b1;
         end
      end

      load_period             = (item_period_ff == '0) ? TIME_BITS'(1) : item_period_ff;
      load_entry.cost         = item_cost_ff;
      load_entry.period       = load_period;
      load_entry.deadline     = item_deadline_ff;
      load_entry.remaining    = item_cost_ff;
      load_entry.next_release = load_period;
      load_entry.phase        = '0;

      run_entry           = best_entry_ff;
      run_entry.remaining = best_entry_ff.remaining - 1'b1;
   end

   // Table port: the scan owns it, except in the completion cycle.
   always_comb begin
      mem_req.rd_en   = scan_issue;
      mem_req.rd_addr = scan_idx_ff[SLOT_BITS-1:0];
      if (state_ff == ST_DONE) begin
         if (func_ff == FUNC_LOAD) begin
            mem_req.wr_en   = out_free;
            mem_req.wr_addr = item_slot_ff;
            mem_req.wr_data = load_entry;
         end else begin
            mem_req.wr_en   = out_free && executed;
            mem_req.wr_addr = best_idx_ff;
            mem_req.wr_data = run_entry;
         end
      end else begin
         mem_req.wr_en   = s2_valid_ff;
         mem_req.wr_addr = s2_idx_ff;
         mem_req.wr_data = s2_wr_entry;
      end
   end

   // Next-state logic.
   always_comb begin
      state_in         = state_ff;
      func_in          = func_ff;
      item_slot_in     = item_slot_ff;
      item_cost_in     = item_cost_ff;
      item_period_in   = item_period_ff;
      item_deadline_in = item_deadline_ff;
      task_count_in    = task_count_ff;
      now_in           = now_ff;
      prev_task_in     = prev_task_ff;
      prev_idle_in     = prev_idle_ff;
      first_tick_in    = first_tick_ff;
      switches_in      = switches_ff;
      preempts_in      = preempts_ff;
      scan_idx_in      = scan_idx_ff;
      rd_valid_in      = scan_issue;
      s2_valid_in      = rd_valid_ff;
      s2_active_in     = s1_active;
      s2_entry_in      = s1_entry;
      found_in         = found_ff;
      best_slack_in    = best_slack_ff;
      best_idx_in      = best_idx_ff;
      best_entry_in    = best_entry_ff;
      pv_rem_in        = pv_rem_ff;
      pv_cost_in       = pv_cost_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_tready;
      rsp_data_in      = rsp_data_ff;

      if (csr_write && (csr_paddr[2] == REG_TASK_COUNT)) begin
         task_count_in = csr_pwdata[TASK_COUNT_BITS-1:0];
      end

      if (s2_take) begin
         found_in      = 1'b1;
         best_slack_in = s2_slack;
         best_idx_in   = s2_idx_ff;
         best_entry_in = s2_wr_entry;
      end
      if (s2_valid_ff && (s2_idx_ff == prev_task_ff)) begin
         pv_rem_in  = s2_entry_ff.remaining;
         pv_cost_in = s2_entry_ff.cost;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               func_in          = func_type'(req_tuser);
               item_slot_in     = req_tdata[4:0];
               item_cost_in     = req_tdata[20:5];
               item_period_in   = req_tdata[36:21];
               item_deadline_in = req_tdata[52:37];
               scan_idx_in      = '0;
               found_in         = 1'b0;
               best_slack_in    = SLACK_BITS'(SLACK_CEILING);
               if ((func_type'(req_tuser) == FUNC_TICK)
                   || (func_type'(req_tuser) == FUNC_CLOSE)) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_SCAN: begin
            if (scan_issue) begin
               scan_idx_in = scan_idx_ff + 1'b1;
            end
            if (scan_drained) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               case (func_ff) inside
                  FUNC_LOAD: begin
                     rsp_data_in   = '0;
                     now_in        = '0;
                     prev_task_in  = '0;
                     prev_idle_in  = 1'b0;
                     first_tick_in = 1'b1;
                     switches_in   = '0;
                     preempts_in   = '0;
                  end
                  FUNC_TICK, FUNC_CLOSE: begin
                     if (sw_bump) begin
                        switches_in = sat_inc(switches_ff);
                     end
                     if (pre_bump) begin
                        preempts_in = sat_inc(preempts_ff);
                     end
                     first_tick_in = 1'b0;
                     prev_idle_in  = cur_idle;
                     prev_task_in  = chosen;
                     now_in        = now_ff + 1'b1;
                     rsp_data_in   = {
                        (pre_bump ? sat_inc(preempts_ff) : preempts_ff),
                        (sw_bump  ? sat_inc(switches_ff) : switches_ff),
                        executed, late, cur_idle, chosen
                     };
                  end
                  default: begin
                     rsp_data_in = {preempts_ff, switches_ff, 1'b0, 1'b0, 1'b1,
                                    {SLOT_BITS{1'b0}}};
                  end
               endcase
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         task_count_ff <= TASK_COUNT_BITS'(1);
         now_ff        <= '0;
         prev_task_ff  <= '0;
         prev_idle_ff  <= 1'b0;
         first_tick_ff <= 1'b1;
         switches_ff   <= '0;
         preempts_ff   <= '0;
         scan_idx_ff   <= '0;
         rd_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         task_count_ff <= task_count_in;
         now_ff        <= now_in;
         prev_task_ff  <= prev_task_in;
         prev_idle_ff  <= prev_idle_in;
         first_tick_ff <= first_tick_in;
         switches_ff   <= switches_in;
         preempts_ff   <= preempts_in;
         scan_idx_ff   <= scan_idx_in;
         rd_valid_ff   <= rd_valid_in;
         s2_valid_ff   <= s2_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      func_ff          <= func_in;
      item_slot_ff     <= item_slot_in;
      item_cost_ff     <= item_cost_in;
      item_period_ff   <= item_period_in;
      item_deadline_ff <= item_deadline_in;
      rd_idx_ff        <= scan_idx_ff[SLOT_BITS-1:0];
      s2_idx_ff        <= rd_idx_ff;
      s2_active_ff     <= s2_active_in;
      s2_entry_ff      <= s2_entry_in;
      found_ff         <= found_in;
      best_slack_ff    <= best_slack_in;
      best_idx_ff      <= best_idx_in;
      best_entry_ff    <= best_entry_in;
      pv_rem_ff        <= pv_rem_in;
      pv_cost_ff       <= pv_cost_in;
      rsp_data_ff      <= rsp_data_in;
   end

`include "least_slack_task_scheduler_assert.svh"

   // A chosen task always lies inside the active slot range.
   `LSTS_ASSERT_IMPLY(a_best_in_range, (state_ff == ST_DONE) && found_ff, ({1'b0, best_idx_ff} < n_eff))
   // The write-back never lands on the slot being read in the same cycle.
   `LSTS_ASSERT_IMPLY(a_no_rw_clash, mem_req.wr_en && mem_req.rd_en, (mem_req.wr_addr != mem_req.rd_addr))
   // After a beat is taken the block is busy in the next cycle.
   `LSTS_ASSERT_NEXT(a_busy_after_beat, req_tvalid && req_tready, !req_tready)

endmodule

>>> design/lsts_task_mem.sv
// Task table: one write port and one registered read port.
module lsts_task_mem
   import lsts_pkg::*;
(
   input  logic           clock,
   input  mem_req_type    mem_req,
   output task_entry_type rd_data
);

   task_entry_type mem_ff [MAX_TASK_SLOTS];
   task_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= mem_ff[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
